### rtl/core/rsi_pkg.sv
// Shared widths, payload words and pipeline context types of the ray-sphere intersection unit.
`timescale 1ns / 1ps
`default_nettype none

package rsi_pkg;

   localparam int COORD_W    = 32;              // one Q16.16 coordinate
   localparam int RADIUS_W   = 31;              // sphere radius register
   localparam int E_W        = COORD_W + 1;     // origin minus center
   localparam int A_W        = 64;              // squared direction length
   localparam int HM_W       = 66;              // magnitude of D.E and of E.E - r^2
   localparam int H_W        = HM_W + 1;        // signed D.E and E.E - r^2
   localparam int LIMB_W     = 33;              // multiplier limb
   localparam int SQ_W       = 66;              // square root result bits
   localparam int RADICAND_W = 2 * SQ_W;        // discriminant
   localparam int N_W        = 67;              // root numerator
   localparam int P_W        = N_W + COORD_W;   // numerator times direction magnitude
   localparam int Q_W        = 34;              // quotient bits kept before clamping
   localparam int DV_STAGES  = Q_W + 1;         // divider pipeline depth

   localparam logic [1:0] CSR_CENTER_X = 2'd0;
   localparam logic [1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [1:0] CSR_CENTER_Z = 2'd2;
   localparam logic [1:0] CSR_RADIUS   = 2'd3;

   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
      logic signed [COORD_W-1:0] dir_x;
      logic signed [COORD_W-1:0] dir_y;
      logic signed [COORD_W-1:0] dir_z;
   } req_type;

   typedef struct packed {
      logic                      hit;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } rsp_type;

   // Which root of the quadratic gives the hit point.
   typedef enum logic [1:0] {
      SEL_NONE,
      SEL_NEAR,       // |H| - S, ray points toward the center from outside
      SEL_FAR_NEG,    // |H| + S
      SEL_FAR_POS     // S - |H|
   } root_sel_type;

   // Per-ray values that ride along the arithmetic.
   typedef struct packed {
      logic [2:0][COORD_W-1:0] origin;
      logic [2:0][COORD_W-1:0] dmag;
      logic [2:0]              dneg;
   } ctx_type;

   typedef struct packed {
      ctx_type          ctx;
      logic [HM_W-1:0]  hmag;
      logic [A_W-1:0]   amag;
      root_sel_type     sel;
   } sq_tag_type;

   typedef struct packed {
      logic               hit;
      logic               dneg;
      logic [COORD_W-1:0] origin;
   } dv_tag_type;

endpackage

`default_nettype wire

### rtl/core/rsi_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module rsi_sqrt (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   input  wire logic [rsi_pkg::RADICAND_W-1:0] in_radicand,
   input  rsi_pkg::sq_tag_type                 in_tag,
   output logic                                out_valid,
   output logic [rsi_pkg::SQ_W-1:0]            out_root,
   output rsi_pkg::sq_tag_type                 out_tag
);
   import rsi_pkg::*;

   localparam int REM_W = SQ_W + 2;

   logic                  valid_ff [SQ_W];
   logic [RADICAND_W-1:0] rad_ff   [SQ_W];
   logic [REM_W-1:0]      rem_ff   [SQ_W];
   logic [SQ_W-1:0]       root_ff  [SQ_W];
   sq_tag_type            tag_ff   [SQ_W];

   for (genvar g = 0; g < SQ_W; g++) begin : g_stage
      logic                  prv_valid;
      logic [RADICAND_W-1:0] prv_rad;
      logic [REM_W-1:0]      prv_rem;
      logic [SQ_W-1:0]       prv_root;
      sq_tag_type            prv_tag;
      logic [REM_W-1:0]      rem_sh;
      logic [REM_W-1:0]      trial;
      logic [REM_W-1:0]      rem_in;
      logic [SQ_W-1:0]       root_in;
      logic                  take;

      if (g == 0) begin : g_first
         assign prv_valid = in_valid;
         assign prv_rad   = in_radicand;
         assign prv_rem   = '0;
         assign prv_root  = '0;
         assign prv_tag   = in_tag;
      end else begin : g_next
         assign prv_valid = valid_ff[g-1];
         assign prv_rad   = rad_ff[g-1];
         assign prv_rem   = rem_ff[g-1];
         assign prv_root  = root_ff[g-1];
         assign prv_tag   = tag_ff[g-1];
      end

      // Bring down the next two radicand bits and try the next root bit.
      assign rem_sh  = {prv_rem[REM_W-3:0], prv_rad[2*(SQ_W-1-g) +: 2]};
      assign trial   = {prv_root, 2'b01};
      assign take    = (rem_sh >= trial);
      assign rem_in  = take ? (rem_sh - trial) : rem_sh;
      assign root_in = {prv_root[SQ_W-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= prv_valid;
         end
         rad_ff[g]  <= prv_rad;
         rem_ff[g]  <= rem_in;
         root_ff[g] <= root_in;
         tag_ff[g]  <= prv_tag;
      end
   end

   assign out_valid = valid_ff[SQ_W-1];
   assign out_root  = root_ff[SQ_W-1];
   assign out_tag   = tag_ff[SQ_W-1];

endmodule

`default_nettype wire

### rtl/core/rsi_div.sv
// Pipelined restoring divider with overflow detect, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module rsi_div (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire logic [rsi_pkg::P_W-1:0] in_num,
   input  wire logic [rsi_pkg::A_W-1:0] in_den,
   input  rsi_pkg::dv_tag_type          in_tag,
   output logic                         out_valid,
   output logic [rsi_pkg::Q_W-1:0]      out_quot,
   output logic                         out_big,
   output rsi_pkg::dv_tag_type          out_tag
);
   import rsi_pkg::*;

   localparam int REM_W = A_W + 1;

   logic             valid_ff [DV_STAGES];
   logic [REM_W-1:0] rem_ff   [DV_STAGES];
   logic [Q_W-1:0]   low_ff   [DV_STAGES];
   logic [A_W-1:0]   den_ff   [DV_STAGES];
   logic [Q_W-1:0]   quot_ff  [DV_STAGES];
   logic             big_ff   [DV_STAGES];
   dv_tag_type       tag_ff   [DV_STAGES];

   // First stage: the quotient reaches 2^Q_W exactly when the upper numerator
   // bits alone are not below the divisor.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      rem_ff[0]  <= in_num[P_W-1:Q_W];
      low_ff[0]  <= in_num[Q_W-1:0];
      den_ff[0]  <= in_den;
      quot_ff[0] <= '0;
      big_ff[0]  <= (in_num[P_W-1:Q_W] >= {1'b0, in_den});
      tag_ff[0]  <= in_tag;
   end

   for (genvar g = 1; g < DV_STAGES; g++) begin : g_stage
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] rem_in;
      logic             take;

      assign rem_sh = {rem_ff[g-1][A_W-1:0], low_ff[g-1][Q_W-g]};
      assign take   = (rem_sh >= {1'b0, den_ff[g-1]});
      assign rem_in = take ? (rem_sh - {1'b0, den_ff[g-1]}) : rem_sh;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= valid_ff[g-1];
         end
         rem_ff[g]  <= rem_in;
         low_ff[g]  <= low_ff[g-1];
         den_ff[g]  <= den_ff[g-1];
         quot_ff[g] <= {quot_ff[g-1][Q_W-2:0], take};
         big_ff[g]  <= big_ff[g-1];
         tag_ff[g]  <= tag_ff[g-1];
      end
   end

   assign out_valid = valid_ff[DV_STAGES-1];
   assign out_quot  = quot_ff[DV_STAGES-1];
   assign out_big   = big_ff[DV_STAGES-1];
   assign out_tag   = tag_ff[DV_STAGES-1];

endmodule

`default_nettype wire

### rtl/core/ray_sphere_intersection_unit.sv
// Top level of the ray-sphere intersection unit: registers, arithmetic pipeline and result.
`timescale 1ns / 1ps
`default_nettype none

// The unit tests one ray per word against a sphere held in four registers.
// A request word (origin and direction, signed Q16.16 per axis) is taken at
// every rising edge where start is high and busy is low. Busy is high only
// while reset is applied, so the unit takes a new ray in every cycle.
// Exactly one response word comes back per ray, in request order, with
// rsp_valid high for one cycle. The word carries the hit flag and the
// intersection point on the nearer non-negative root, saturated to Q16.16;
// the point is zero when there is no hit.
// The square root, which makes one result bit per stage over 66 stages,
// and the three dividers, with 35 stages each, make up most of the
// pipeline; the remaining stages hold the products and sums.
// Throughput is one ray per cycle: the pipeline has no feedback and advances
// every cycle. The receiver cannot hold off results, so nothing ever stalls.
// Reset clears all valid bits and loads the center with the origin and the
// radius with 1.0. The csr_ port writes a register and should
// be used only while no ray is in flight.

module ray_sphere_intersection_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  rsi_pkg::req_type                 req_word,
   output logic                             rsp_valid,
   output rsi_pkg::rsp_type                 rsp_word,
   input  wire logic                        csr_wen,
   input  wire logic [1:0]                  csr_index,
   input  wire logic [rsi_pkg::COORD_W-1:0] csr_wdata
);
   import rsi_pkg::*;

   // Configuration registers.
   logic [2:0][COORD_W-1:0] center_ff;
   logic [RADIUS_W-1:0]     radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         radius_ff <= RADIUS_W'(65536);
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_CENTER_X: center_ff[0] <= csr_wdata;
            CSR_CENTER_Y: center_ff[1] <= csr_wdata;
            CSR_CENTER_Z: center_ff[2] <= csr_wdata;
            CSR_RADIUS:   radius_ff    <= csr_wdata[RADIUS_W-1:0];
            default:      radius_ff    <= radius_ff;
         endcase
      end
   end

   assign busy = reset;

   // Input register.
   logic    in_valid_ff;
   req_type in_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start & ~busy;
      end
      in_word_ff <= req_word;
   end

   // Stage 1: offset from the center and direction magnitudes.
   logic [2:0][COORD_W-1:0] in_org;
   logic [2:0][COORD_W-1:0] in_dir;
   logic [E_W-1:0]          s1_e_in [3];
   ctx_type                 s1_ctx_in;
   logic                    s1_valid_ff;
   logic [E_W-1:0]          s1_e_ff [3];
   ctx_type                 s1_ctx_ff;

   assign in_org = {in_word_ff.origin_z, in_word_ff.origin_y, in_word_ff.origin_x};
   assign in_dir = {in_word_ff.dir_z, in_word_ff.dir_y, in_word_ff.dir_x};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_e_in[i] = {in_org[i][COORD_W-1], in_org[i]}
                    - {center_ff[i][COORD_W-1], center_ff[i]};
         s1_ctx_in.origin[i] = in_org[i];
         s1_ctx_in.dneg[i]   = in_dir[i][COORD_W-1];
         s1_ctx_in.dmag[i]   = in_dir[i][COORD_W-1] ? (COORD_W'(0) - in_dir[i]) : in_dir[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid_ff;
      end
      s1_e_ff   <= s1_e_in;
      s1_ctx_ff <= s1_ctx_in;
   end

   // Stage 2: offset magnitudes. They stay below 2^32.
   logic [E_W-1:0]     s2_eabs [3];
   logic               s2_valid_ff;
   logic [COORD_W-1:0] s2_emag_ff [3];
   logic [2:0]         s2_eneg_ff;
   ctx_type            s2_ctx_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_eabs[i] = s1_e_ff[i][E_W-1] ? (E_W'(0) - s1_e_ff[i]) : s1_e_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      for (int i = 0; i < 3; i++) begin
         s2_emag_ff[i] <= s2_eabs[i][COORD_W-1:0];
         s2_eneg_ff[i] <= s1_e_ff[i][E_W-1];
      end
      s2_ctx_ff <= s1_ctx_ff;
   end

   // Stage 3: per-axis products and the squared radius.
   logic                  s3_valid_ff;
   logic [A_W-1:0]        s3_dd_ff [3];
   logic [A_W-1:0]        s3_de_ff [3];
   logic [2:0]            s3_deneg_ff;
   logic [A_W-1:0]        s3_ee_ff [3];
   logic [2*RADIUS_W-1:0] s3_rr_ff;
   ctx_type               s3_ctx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      for (int i = 0; i < 3; i++) begin
         s3_dd_ff[i]    <= s2_ctx_ff.dmag[i] * s2_ctx_ff.dmag[i];
         s3_de_ff[i]    <= s2_ctx_ff.dmag[i] * s2_emag_ff[i];
         s3_deneg_ff[i] <= s2_ctx_ff.dneg[i] ^ s2_eneg_ff[i];
         s3_ee_ff[i]    <= s2_emag_ff[i] * s2_emag_ff[i];
      end
      s3_rr_ff  <= radius_ff * radius_ff;
      s3_ctx_ff <= s2_ctx_ff;
   end

   // Stage 4: A = D.D, H = D.E and K = E.E - r^2.
   logic [H_W-1:0]  s4_term [3];
   logic [HM_W-1:0] s4_eesum;
   logic            s4_valid_ff;
   logic [A_W-1:0]  s4_a_ff;
   logic [H_W-1:0]  s4_h_ff;
   logic [H_W-1:0]  s4_k_ff;
   ctx_type         s4_ctx_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s4_term[i] = s3_deneg_ff[i] ? (H_W'(0) - {3'b0, s3_de_ff[i]}) : {3'b0, s3_de_ff[i]};
      end
      s4_eesum = {2'b0, s3_ee_ff[0]} + {2'b0, s3_ee_ff[1]} + {2'b0, s3_ee_ff[2]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_a_ff   <= s3_dd_ff[0] + s3_dd_ff[1] + s3_dd_ff[2];
      s4_h_ff   <= s4_term[0] + s4_term[1] + s4_term[2];
      s4_k_ff   <= {1'b0, s4_eesum} - {5'b0, s3_rr_ff};
      s4_ctx_ff <= s3_ctx_ff;
   end

   // Stage 5: signs and magnitudes of H and K.
   logic            s5_valid_ff;
   logic [HM_W-1:0] s5_hmag_ff;
   logic [HM_W-1:0] s5_kmag_ff;
   logic            s5_h_le0_ff;
   logic            s5_k_lt0_ff;
   logic            s5_k_zero_ff;
   logic            s5_a_zero_ff;
   logic [A_W-1:0]  s5_a_ff;
   ctx_type         s5_ctx_ff;
   logic [H_W-1:0]  s5_habs;
   logic [H_W-1:0]  s5_kabs;

   assign s5_habs = s4_h_ff[H_W-1] ? (H_W'(0) - s4_h_ff) : s4_h_ff;
   assign s5_kabs = s4_k_ff[H_W-1] ? (H_W'(0) - s4_k_ff) : s4_k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
      s5_hmag_ff   <= s5_habs[HM_W-1:0];
      s5_kmag_ff   <= s5_kabs[HM_W-1:0];
      s5_h_le0_ff  <= s4_h_ff[H_W-1] | (s4_h_ff == '0);
      s5_k_lt0_ff  <= s4_k_ff[H_W-1];
      s5_k_zero_ff <= (s4_k_ff == '0);
      s5_a_zero_ff <= (s4_a_ff == '0);
      s5_a_ff      <= s4_a_ff;
      s5_ctx_ff    <= s4_ctx_ff;
   end

   // Stage 6: limb products of H^2 and A*K.
   logic [LIMB_W-1:0]   s6_h0, s6_h1, s6_a0, s6_a1, s6_k0, s6_k1;
   logic                s6_valid_ff;
   logic [2*LIMB_W-1:0] s6_hh00_ff, s6_hhmid_ff, s6_hh11_ff;
   logic [2*LIMB_W-1:0] s6_ak00_ff, s6_ak01_ff, s6_ak10_ff, s6_ak11_ff;
   logic                s6_h_le0_ff, s6_k_lt0_ff, s6_k_zero_ff, s6_a_zero_ff;
   logic [HM_W-1:0]     s6_hmag_ff;
   logic [A_W-1:0]      s6_a_ff;
   ctx_type             s6_ctx_ff;

   assign s6_h0 = s5_hmag_ff[LIMB_W-1:0];
   assign s6_h1 = s5_hmag_ff[HM_W-1:LIMB_W];
   assign s6_a0 = s5_a_ff[LIMB_W-1:0];
   assign s6_a1 = {2'b0, s5_a_ff[A_W-1:LIMB_W]};
   assign s6_k0 = s5_kmag_ff[LIMB_W-1:0];
   assign s6_k1 = s5_kmag_ff[HM_W-1:LIMB_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= s5_valid_ff;
      end
      s6_hh00_ff   <= s6_h0 * s6_h0;
      s6_hhmid_ff  <= s6_h0 * s6_h1;
      s6_hh11_ff   <= s6_h1 * s6_h1;
      s6_ak00_ff   <= s6_a0 * s6_k0;
      s6_ak01_ff   <= s6_a0 * s6_k1;
      s6_ak10_ff   <= s6_a1 * s6_k0;
      s6_ak11_ff   <= s6_a1 * s6_k1;
      s6_h_le0_ff  <= s5_h_le0_ff;
      s6_k_lt0_ff  <= s5_k_lt0_ff;
      s6_k_zero_ff <= s5_k_zero_ff;
      s6_a_zero_ff <= s5_a_zero_ff;
      s6_hmag_ff   <= s5_hmag_ff;
      s6_a_ff      <= s5_a_ff;
      s6_ctx_ff    <= s5_ctx_ff;
   end

   // Stage 7: assemble H^2 and A*K.
   logic [2*LIMB_W:0]     s7_akmid;
   logic                  s7_valid_ff;
   logic [RADICAND_W-1:0] s7_hh_ff, s7_ak_ff;
   logic                  s7_h_le0_ff, s7_k_lt0_ff, s7_k_zero_ff, s7_a_zero_ff;
   logic [HM_W-1:0]       s7_hmag_ff;
   logic [A_W-1:0]        s7_a_ff;
   ctx_type               s7_ctx_ff;

   assign s7_akmid = {1'b0, s6_ak01_ff} + {1'b0, s6_ak10_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else begin
         s7_valid_ff <= s6_valid_ff;
      end
      // The middle term of a square appears twice, hence the extra shift.
      s7_hh_ff <= {s6_hh11_ff, 66'b0} + {32'b0, s6_hhmid_ff, 34'b0} + {66'b0, s6_hh00_ff};
      s7_ak_ff <= {s6_ak11_ff, 66'b0} + {32'b0, s7_akmid, 33'b0} + {66'b0, s6_ak00_ff};
      s7_h_le0_ff  <= s6_h_le0_ff;
      s7_k_lt0_ff  <= s6_k_lt0_ff;
      s7_k_zero_ff <= s6_k_zero_ff;
      s7_a_zero_ff <= s6_a_zero_ff;
      s7_hmag_ff   <= s6_hmag_ff;
      s7_a_ff      <= s6_a_ff;
      s7_ctx_ff    <= s6_ctx_ff;
   end

   // Stage 8: discriminant H^2 - A*K and the choice of root.
   logic                  s8_disc_neg;
   root_sel_type          s8_sel;
   logic                  s8_valid_ff;
   logic [RADICAND_W-1:0] s8_disc_ff;
   sq_tag_type            s8_tag_ff;

   assign s8_disc_neg = ~s7_k_lt0_ff & (s7_hh_ff < s7_ak_ff);

   // A ray that starts outside the sphere (K > 0) and points away from it
   // (H > 0) misses, and so does a tangent touch behind the origin.
   always_comb begin
      priority if (s7_a_zero_ff || s8_disc_neg) begin
         s8_sel = SEL_NONE;
      end else if (s7_h_le0_ff && !s7_k_lt0_ff) begin
         s8_sel = SEL_NEAR;
      end else if (s7_h_le0_ff) begin
         s8_sel = SEL_FAR_NEG;
      end else if (s7_k_lt0_ff || s7_k_zero_ff) begin
         s8_sel = SEL_FAR_POS;
      end else begin
         s8_sel = SEL_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else begin
         s8_valid_ff <= s7_valid_ff;
      end
      s8_disc_ff     <= s7_k_lt0_ff ? (s7_hh_ff + s7_ak_ff) : (s7_hh_ff - s7_ak_ff);
      s8_tag_ff.ctx  <= s7_ctx_ff;
      s8_tag_ff.hmag <= s7_hmag_ff;
      s8_tag_ff.amag <= s7_a_ff;
      s8_tag_ff.sel  <= s8_sel;
   end

   // Square root of the discriminant.
   logic            sq_valid;
   logic [SQ_W-1:0] sq_root;
   sq_tag_type      sq_tag;

   rsi_sqrt u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s8_valid_ff),
      .in_radicand (s8_disc_ff),
      .in_tag      (s8_tag_ff),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_tag     (sq_tag)
   );

   // Stage 9: numerator of the chosen root. It is never negative.
   logic [N_W-1:0] s9_n;
   logic           s9_valid_ff;
   logic [N_W-1:0] s9_n_ff;
   logic           s9_hit_ff;
   logic [A_W-1:0] s9_a_ff;
   ctx_type        s9_ctx_ff;

   always_comb begin
      unique case (sq_tag.sel)
         SEL_NEAR:    s9_n = {1'b0, sq_tag.hmag} - {1'b0, sq_root};
         SEL_FAR_NEG: s9_n = {1'b0, sq_tag.hmag} + {1'b0, sq_root};
         SEL_FAR_POS: s9_n = {1'b0, sq_root} - {1'b0, sq_tag.hmag};
         default:     s9_n = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_valid_ff <= 1'b0;
      end else begin
         s9_valid_ff <= sq_valid;
      end
      s9_n_ff   <= s9_n;
      s9_hit_ff <= (sq_tag.sel != SEL_NONE);
      s9_a_ff   <= sq_tag.amag;
      s9_ctx_ff <= sq_tag.ctx;
   end

   // Stage 10: limb products of N and each direction magnitude.
   logic                      s10_valid_ff;
   logic [LIMB_W+COORD_W-1:0] s10_lo_ff [3];
   logic [P_W-LIMB_W-1:0]     s10_hi_ff [3];
   logic                      s10_hit_ff;
   logic [A_W-1:0]            s10_a_ff;
   ctx_type                   s10_ctx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_valid_ff <= 1'b0;
      end else begin
         s10_valid_ff <= s9_valid_ff;
      end
      for (int i = 0; i < 3; i++) begin
         s10_lo_ff[i] <= s9_n_ff[LIMB_W-1:0] * s9_ctx_ff.dmag[i];
         s10_hi_ff[i] <= s9_n_ff[N_W-1:LIMB_W] * s9_ctx_ff.dmag[i];
      end
      s10_hit_ff <= s9_hit_ff;
      s10_a_ff   <= s9_a_ff;
      s10_ctx_ff <= s9_ctx_ff;
   end

   // Stage 11: full products N * |D| per axis.
   logic           s11_valid_ff;
   logic [P_W-1:0] s11_p_ff [3];
   dv_tag_type     s11_tag_ff [3];
   logic [A_W-1:0] s11_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s11_valid_ff <= 1'b0;
      end else begin
         s11_valid_ff <= s10_valid_ff;
      end
      for (int i = 0; i < 3; i++) begin
         s11_p_ff[i] <= {s10_hi_ff[i], 33'b0} + {34'b0, s10_lo_ff[i]};
         s11_tag_ff[i].hit    <= s10_hit_ff;
         s11_tag_ff[i].dneg   <= s10_ctx_ff.dneg[i];
         s11_tag_ff[i].origin <= s10_ctx_ff.origin[i];
      end
      s11_a_ff <= s10_a_ff;
   end

   // Per-axis division by A. All three run in lockstep, so the first one's
   // valid and hit flag stand for the word.
   logic           dv_valid;
   logic [Q_W-1:0] dv_quot [3];
   logic           dv_big  [3];
   dv_tag_type     dv_tag  [3];

   for (genvar a = 0; a < 3; a++) begin : g_axis
      if (a == 0) begin : g_lead
         rsi_div u_div (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (s11_valid_ff),
            .in_num    (s11_p_ff[a]),
            .in_den    (s11_a_ff),
            .in_tag    (s11_tag_ff[a]),
            .out_valid (dv_valid),
            .out_quot  (dv_quot[a]),
            .out_big   (dv_big[a]),
            .out_tag   (dv_tag[a])
         );
      end else begin : g_follow
         rsi_div u_div (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (s11_valid_ff),
            .in_num    (s11_p_ff[a]),
            .in_den    (s11_a_ff),
            .in_tag    (s11_tag_ff[a]),
            .out_valid (),
            .out_quot  (dv_quot[a]),
            .out_big   (dv_big[a]),
            .out_tag   (dv_tag[a])
         );
      end
   end

   // Output stage: clamp the step to 2^33, move from the origin along the
   // direction's sign, then saturate to the 32-bit range.
   logic [2:0][COORD_W-1:0] out_point;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_word_ff;

   always_comb begin
      logic [Q_W-1:0]     qm;
      logic [COORD_W+2:0] oext;
      logic [COORD_W+2:0] sum;
      for (int i = 0; i < 3; i++) begin
         qm = (dv_big[i] || (dv_quot[i][Q_W-1] && (dv_quot[i][Q_W-2:0] != '0)))
            ? {1'b1, {(Q_W-1){1'b0}}} : dv_quot[i];
         oext = {{3{dv_tag[i].origin[COORD_W-1]}}, dv_tag[i].origin};
         sum  = dv_tag[i].dneg ? (oext - {1'b0, qm}) : (oext + {1'b0, qm});
         priority if (sum[COORD_W+2:COORD_W-1] == '0 || sum[COORD_W+2:COORD_W-1] == '1) begin
            out_point[i] = sum[COORD_W-1:0];
         end else if (sum[COORD_W+2]) begin
            out_point[i] = {1'b1, {(COORD_W-1){1'b0}}};
         end else begin
            out_point[i] = {1'b0, {(COORD_W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid;
      end
      rsp_word_ff.hit     <= dv_tag[0].hit;
      rsp_word_ff.point_x <= dv_tag[0].hit ? out_point[0] : '0;
      rsp_word_ff.point_y <= dv_tag[0].hit ? out_point[1] : '0;
      rsp_word_ff.point_z <= dv_tag[0].hit ? out_point[2] : '0;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for the ray-sphere intersection unit.
`timescale 1ns / 1ps

module tb;
   import rsi_pkg::*;

   localparam int Q1        = 65536;    // 1.0 in Q16.16
   localparam int LATENCY   = 114;
   localparam int MAX_CYC   = 600000;
   localparam int N_PHASES  = 8;
   localparam int PHASE_LEN = 230;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_word;
   logic             rsp_valid;
   rsp_type          rsp_word;
   logic             csr_wen;
   logic [1:0]       csr_index;
   logic [31:0]      csr_wdata;

   // Sphere as the predictor sees it, updated when a register write lands.
   logic signed [31:0] sph_center [3];
   logic [30:0]        sph_radius;

   // Row of the directed table: a ray and, where it is obvious, its answer.
   typedef struct {
      req_type rq;
      bit      typed;
      rsp_type want;
   } ray_row_type;

   ray_row_type ray_table [$];
   rsp_type   hit_q [$];       // expected response words, oldest first
   bit        cur_typed;
   rsp_type   cur_want;
   int        mismatches;
   int        cycles;
   int        timed_out;

   ray_sphere_intersection_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Exact integer solution of the ray-sphere quadratic. The fraction scale
   // cancels out, so the raw Q16.16 integers are used throughout. Sums of
   // products are kept exact in wide vectors; only the squared direction
   // length wraps at 64 bits, as it does in the hardware.
   function automatic rsp_type sphere_hit(req_type rq);
      logic signed [255:0] ov [3];
      logic signed [255:0] dv [3];
      logic signed [255:0] ev [3];
      logic signed [255:0] h, ee, rr, k;
      logic [255:0]        a, hm, km, hh, ak, disc, s, t, n, dm, q;
      logic [63:0]         amag;
      longint              p;
      rsp_type             r;
      ov[0] = $signed(rq.origin_x);
      ov[1] = $signed(rq.origin_y);
      ov[2] = $signed(rq.origin_z);
      dv[0] = $signed(rq.dir_x);
      dv[1] = $signed(rq.dir_y);
      dv[2] = $signed(rq.dir_z);
      r = '0;
      h = 0;
      ee = 0;
      amag = '0;
      for (int i = 0; i < 3; i++) begin
         ev[i] = ov[i] - $signed(sph_center[i]);
         amag += 64'(dv[i] * dv[i]);
         h += dv[i] * ev[i];
         ee += ev[i] * ev[i];
      end
      // A zero-length direction cannot meet anything.
      if (amag == 0) return r;
      a = {192'b0, amag};
      rr = $signed({225'b0, sph_radius});
      rr = rr * rr;
      k = ee - rr;
      hm = (h < 0) ? -h : h;
      km = (k < 0) ? -k : k;
      hh = hm * hm;
      ak = a * km;
      if (k < 0) begin
         disc = hh + ak;
      end else begin
         // Negative discriminant: the line misses the sphere.
         if (hh < ak) return r;
         disc = hh - ak;
      end
      s = '0;
      for (int i = 95; i >= 0; i--) begin
         t = s | (256'd1 << i);
         if (t * t <= disc) s = t;
      end
      // Near root from outside when facing the center, far root from inside
      // or from the surface when facing away; otherwise both roots lie behind the origin,
      // which also covers a tangent touch behind it.
      if (h <= 0 && k >= 0) n = hm - s;
      else if (h <= 0) n = hm + s;
      else if (k <= 0) n = s - hm;
      else return r;
      r.hit = 1'b1;
      for (int i = 0; i < 3; i++) begin
         dm = (dv[i] < 0) ? -dv[i] : dv[i];
         q = (n * dm) / a;
         if (q > (256'd1 << 33)) q = 256'd1 << 33;
         p = (dv[i] < 0) ? longint'(ov[i]) - longint'(q) : longint'(ov[i]) + longint'(q);
         if (p > 64'sd2147483647) p = 64'sd2147483647;
         if (p < -64'sd2147483648) p = -64'sd2147483648;
         case (i)
            0: r.point_x = p[31:0];
            1: r.point_y = p[31:0];
            default: r.point_z = p[31:0];
         endcase
      end
      return r;
   endfunction

   // Accepted words are predicted here; response words are checked here.
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset) begin
         if (start && !busy) hit_q.push_back(cur_typed ? cur_want : sphere_hit(req_word));
         if (rsp_valid) begin
            got = rsp_word;
            if (hit_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("tb: response word with none expected: %p", got);
            end else begin
               want = hit_q.pop_front();
               if (got.hit !== want.hit || got.point_x !== want.point_x ||
                   got.point_y !== want.point_y || got.point_z !== want.point_z) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("tb: mismatch expected hit=%0b p=(%0d,%0d,%0d) got hit=%0b p=(%0d,%0d,%0d)",
                              want.hit, want.point_x, want.point_y, want.point_z,
                              got.hit, got.point_x, got.point_y, got.point_z);
               end
            end
         end
      end
   end

   // The watchdog ends a run that hangs.
   always @(posedge clock) begin
      cycles++;
      if (cycles == MAX_CYC) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // Random gap before a word: mostly none or short, now and then long.
   task automatic idle_gap();
      int g;
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) g = 0;
      else if (roll < 92) g = $urandom_range(1, 4);
      else g = $urandom_range(10, 60);
      if (g > 0) begin
         start <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // Present one ray and hold it until an edge with busy low takes it.
   task automatic send_ray(req_type rq, bit typed, rsp_type want);
      idle_gap();
      start <= 1'b1;
      req_word <= rq;
      cur_typed <= typed;
      cur_want <= want;
      forever begin
         @(negedge clock);
         if (!busy) break;
         @(posedge clock);
      end
      @(posedge clock);
   endtask

   // One register write; the enable drops before the next one.
   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_CENTER_X: sph_center[0] = val;
         CSR_CENTER_Y: sph_center[1] = val;
         CSR_CENTER_Z: sph_center[2] = val;
         default:      sph_center[0] = sph_center[0];
      endcase
      if (idx == CSR_RADIUS) sph_radius = val[30:0];
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   // Block until every expected word has arrived, then let the pipe settle.
   task automatic drain();
      int n;
      start <= 1'b0;
      n = 0;
      while (hit_q.size() != 0 && n < 50 * LATENCY) begin
         @(posedge clock);
         n++;
      end
      if (hit_q.size() != 0) timed_out = 1;
      repeat (8) @(posedge clock);
   endtask

   function automatic req_type make_ray(int ox, int oy, int oz, int dx, int dy, int dz);
      req_type rq;
      rq.origin_x = ox;
      rq.origin_y = oy;
      rq.origin_z = oz;
      rq.dir_x = dx;
      rq.dir_y = dy;
      rq.dir_z = dz;
      return rq;
   endfunction

   function automatic rsp_type make_hit(bit h, int px, int py, int pz);
      rsp_type r;
      r.hit = h;
      r.point_x = px;
      r.point_y = py;
      r.point_z = pz;
      return r;
   endfunction

   task automatic add_row(req_type rq, bit typed, rsp_type want);
      ray_row_type row;
      row.rq = rq;
      row.typed = typed;
      row.want = want;
      ray_table.push_back(row);
   endtask

   // A random ray. Most are aimed roughly at the sphere from a random nearby
   // origin so that hits, misses and inside starts all show up; the rest are
   // pure noise across the full range of every field.
   function automatic req_type random_ray();
      req_type rq;
      int off [3];
      int org [3];
      int dir [3];
      if ($urandom_range(0, 9) < 2) begin
         rq = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         return rq;
      end
      for (int i = 0; i < 3; i++) begin
         off[i] = int'($urandom) >>> $urandom_range(2, 31);
         org[i] = sph_center[i] + off[i];
         dir[i] = (sph_center[i] - org[i]) + (int'($urandom) >>> $urandom_range(6, 31));
         dir[i] = dir[i] >>> $urandom_range(0, 12);
      end
      if ($urandom_range(0, 7) == 0) begin
         dir[0] = -dir[0];
         dir[1] = -dir[1];
         dir[2] = -dir[2];
      end
      return make_ray(org[0], org[1], org[2], dir[0], dir[1], dir[2]);
   endfunction

   initial begin
      rsp_type none;
      none = '0;
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      csr_wen = 1'b0;
      csr_index = CSR_CENTER_X;
      csr_wdata = '0;
      cur_typed = 1'b0;
      cur_want = '0;
      mismatches = 0;
      cycles = 0;
      timed_out = 0;
      sph_center[0] = 0;
      sph_center[1] = 0;
      sph_center[2] = 0;
      sph_radius = 31'(Q1);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rays against the unit sphere at the origin left by reset.
      add_row(make_ray(0, 0, -5 * Q1, 0, 0, Q1), 1, make_hit(1, 0, 0, -Q1));
      add_row(make_ray(0, 0, 5 * Q1, 0, 0, -Q1), 1, make_hit(1, 0, 0, Q1));
      add_row(make_ray(0, 0, 0, Q1, 0, 0), 1, make_hit(1, Q1, 0, 0));
      add_row(make_ray(0, 0, 0, 0, -Q1, 0), 1, make_hit(1, 0, -Q1, 0));
      add_row(make_ray(Q1, 0, -5 * Q1, 0, 0, Q1), 1, make_hit(1, Q1, 0, 0));
      add_row(make_ray(Q1, 0, 5 * Q1, 0, 0, Q1), 1, none);
      add_row(make_ray(0, 0, 5 * Q1, 0, 0, Q1), 1, none);
      add_row(make_ray(5 * Q1, 5 * Q1, -5 * Q1, 0, 0, Q1), 1, none);
      add_row(make_ray(0, 0, -5 * Q1, 0, 0, 0), 1, none);
      add_row(make_ray(0, 0, 0, 0, 0, 0), 1, none);
      add_row(make_ray(0, 0, Q1, 0, 0, Q1), 1, make_hit(1, 0, 0, Q1));
      add_row(make_ray(0, 0, -5 * Q1, 0, 0, 1), 0, none);
      add_row(make_ray(0, 0, -5 * Q1, 0, 0, 32'h7fffffff), 0, none);
      add_row(make_ray(0, 0, -5 * Q1, 0, 0, 32'h80000000), 0, none);
      add_row(make_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       32'h80000000, 32'h80000000, 32'h80000000), 0, none);
      add_row(make_ray(32'h80000000, 32'h80000000, 32'h80000000,
                       32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 0, none);
      add_row(make_ray(32'h80000000, 32'h7fffffff, 32'h80000000,
                       32'h7fffffff, 32'h80000000, 32'h7fffffff), 0, none);
      add_row(make_ray(32'hffffffff, 32'hffffffff, 32'hffffffff,
                       32'hffffffff, 32'hffffffff, 32'hffffffff), 0, none);
      add_row(make_ray(3, -2, 1, -3, 2, -1), 0, none);
      add_row(make_ray(Q1 / 2, Q1 / 3, -Q1, 1, 1, 32'h40000000), 0, none);
      foreach (ray_table[i]) send_ray(ray_table[i].rq, ray_table[i].typed, ray_table[i].want);
      drain();

      // Random phases, each under its own sphere; the first ones take the
      // register extremes, and bit 31 of the radius word is driven too.
      for (int ph = 0; ph < N_PHASES; ph++) begin
         case (ph)
            0: begin
               write_reg(CSR_CENTER_X, 32'h7fffffff);
               write_reg(CSR_CENTER_Y, 32'h7fffffff);
               write_reg(CSR_CENTER_Z, 32'h7fffffff);
               write_reg(CSR_RADIUS, 32'hffffffff);
            end
            1: begin
               write_reg(CSR_CENTER_X, 32'h80000000);
               write_reg(CSR_CENTER_Y, 32'h80000000);
               write_reg(CSR_CENTER_Z, 32'h80000000);
               write_reg(CSR_RADIUS, 32'h0);
            end
            2: begin
               write_reg(CSR_CENTER_X, 0);
               write_reg(CSR_CENTER_Y, 0);
               write_reg(CSR_CENTER_Z, 0);
               write_reg(CSR_RADIUS, 32'h80000000 | Q1);
            end
            default: begin
               write_reg(CSR_CENTER_X, int'($urandom) >>> $urandom_range(0, 20));
               write_reg(CSR_CENTER_Y, int'($urandom) >>> $urandom_range(0, 20));
               write_reg(CSR_CENTER_Z, int'($urandom) >>> $urandom_range(0, 20));
               write_reg(CSR_RADIUS, $urandom >> $urandom_range(0, 24));
            end
         endcase
         @(posedge clock);
         for (int n = 0; n < PHASE_LEN; n++) send_ray(random_ray(), 0, none);
         drain();
      end

      repeat (LATENCY + 20) @(posedge clock);
      if (mismatches == 0 && timed_out == 0 && hit_q.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/rsi_pkg.sv
rtl/core/rsi_sqrt.sv
rtl/core/rsi_div.sv
rtl/core/ray_sphere_intersection_unit.sv
tb/sv/tb.sv
